>>> design/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> design/rvalu_pkg.sv
package rvalu_pkg;

	localparam int XLEN      = 32;
	localparam int DIV_STEPS = XLEN;
	localparam int SHW       = 5;

	localparam logic [6:0] F7_MULDIV = 7'h01;
	localparam logic [6:0] F7_ALT    = 7'h20;

	// base operations
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	// m extension
	localparam logic [2:0] F3_MUL    = 3'd0;
	localparam logic [2:0] F3_MULH   = 3'd1;
	localparam logic [2:0] F3_MULHSU = 3'd2;
	localparam logic [2:0] F3_MULHU  = 3'd3;
	localparam logic [2:0] F3_DIV    = 3'd4;
	localparam logic [2:0] F3_DIVU   = 3'd5;
	localparam logic [2:0] F3_REM    = 3'd6;
	localparam logic [2:0] F3_REMU   = 3'd7;

	// what rides along with a request through the divider
	typedef struct packed {
		logic [XLEN-1:0] other;
		logic            is_div;
		logic            is_rem;
		logic            neg_q;
		logic            neg_r;
		logic [4:0]      rd;
	} side_t;

endpackage

>>> design/rvalu_divpipe.sv
module rvalu_divpipe (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [rvalu_pkg::XLEN-1:0] in_dividend,
	input  logic [rvalu_pkg::XLEN-1:0] in_divisor,
	input  rvalu_pkg::side_t          in_side,
	output logic                      out_valid,
	output logic [rvalu_pkg::XLEN-1:0] out_quot,
	output logic [rvalu_pkg::XLEN-1:0] out_rem,
	output rvalu_pkg::side_t          out_side
);
	import rvalu_pkg::*;

	// one restoring step per stage, quotient bits shift in behind the dividend
	logic            vld_s  [0:DIV_STEPS];
	logic [XLEN-1:0] rem_s  [0:DIV_STEPS];
	logic [XLEN-1:0] quo_s  [0:DIV_STEPS];
	logic [XLEN-1:0] dvs_s  [0:DIV_STEPS-1];
	side_t           side_s [0:DIV_STEPS];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign quo_s[0]  = in_dividend;
	assign dvs_s[0]  = in_divisor;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [XLEN:0] trial;
		logic [XLEN:0] diff;

		assign trial = {rem_s[i], quo_s[i][XLEN-1]};
		assign diff  = trial - {1'b0, dvs_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[XLEN]) begin
					rem_s[i+1] <= diff[XLEN-1:0];
				end else begin
					rem_s[i+1] <= trial[XLEN-1:0];
				end
				quo_s[i+1]  <= {quo_s[i][XLEN-2:0], ~diff[XLEN]};
				side_s[i+1] <= side_s[i];
			end
		end

		// the last step has no one left to hand the divisor to
		if (i < DIV_STEPS-1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					dvs_s[i+1] <= dvs_s[i];
				end
			end
		end
	end

	assign out_valid = vld_s[DIV_STEPS];
	assign out_quot  = quo_s[DIV_STEPS];
	assign out_rem   = rem_s[DIV_STEPS];
	assign out_side  = side_s[DIV_STEPS];

endmodule

>>> design/rv32im_integer_alu.sv
// a request passes s1, s2, s3, the divider spine, then the output register
// one request per cycle unless stalled; the 32-stage restoring divider spine sets latency
// every operation travels the same spine, so results leave in request order
// a stalled result freezes the whole pipe; no request is lost or repeated
// reset (arst_n low) clears all valid bits at once, payload registers keep junk
module rv32im_integer_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	output logic        instr_stall,
	input  logic [31:0] instruction,
	input  logic [31:0] first_operand,
	input  logic [31:0] second_operand,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] result_value,
	output logic [4:0]  dest_index,
	output logic        write_enable
);
	import rvalu_pkg::*;

	// global advance: the pipe moves unless the output holds a stalled result
	logic en;
	assign en          = !(result_valid && result_stall);
	assign instr_stall = !en;

	// ---------------- decode (s1) ----------------
	logic            reg_form;
	logic [6:0]      f7_in;
	logic [2:0]      f3_in;
	logic [XLEN-1:0] imm_in;

	assign reg_form = instruction[5];
	assign f7_in    = instruction[31:25];
	assign f3_in    = instruction[14:12];
	assign imm_in   = {{(XLEN-12){instruction[31]}}, instruction[31:20]};

	logic            vld_s1;
	logic [XLEN-1:0] a_s1;
	logic [XLEN-1:0] b_s1;
	logic [2:0]      f3_s1;
	logic            alt_s1;
	logic            is_m_s1;
	logic [4:0]      rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= instr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= first_operand;
			b_s1    <= reg_form ? second_operand : imm_in;
			f3_s1   <= f3_in;
			// sub/sra only with funct7 0x20; immediate form only has srai
			alt_s1  <= reg_form ? (f7_in == F7_ALT) : ((f3_in == F3_SR) && instruction[30]);
			is_m_s1 <= reg_form && (f7_in == F7_MULDIV);
			rd_s1   <= instruction[11:7];
		end
	end

	// ---------------- base op, partial products, divide prep (s2) ----------------
	logic [SHW-1:0]  sh;
	logic [XLEN-1:0] base_res;

	assign sh = b_s1[SHW-1:0];

	always_comb begin
		case (f3_s1)
			F3_ADD:  base_res = alt_s1 ? (a_s1 - b_s1) : (a_s1 + b_s1);
			F3_SLL:  base_res = a_s1 << sh;
			F3_SLT:  base_res = {{(XLEN-1){1'b0}}, ($signed(a_s1) < $signed(b_s1))};
			F3_SLTU: base_res = {{(XLEN-1){1'b0}}, (a_s1 < b_s1)};
			F3_XOR:  base_res = a_s1 ^ b_s1;
			F3_SR:   base_res = alt_s1 ? XLEN'($signed(a_s1) >>> sh) : (a_s1 >> sh);
			F3_OR:   base_res = a_s1 | b_s1;
			F3_AND:  base_res = a_s1 & b_s1;
			default: base_res = '0;
		endcase
	end

	// 33-bit signed operands for the multiplier, split into 16-bit low and 17-bit high
	logic        a_sgn;
	logic        b_sgn;
	logic [32:0] ax;
	logic [32:0] bx;

	assign a_sgn = (f3_s1 == F3_MULH) || (f3_s1 == F3_MULHSU);
	assign b_sgn = (f3_s1 == F3_MULH);
	assign ax    = {a_sgn & a_s1[XLEN-1], a_s1};
	assign bx    = {b_sgn & b_s1[XLEN-1], b_s1};

	// divider operands and sign fixups
	logic            div_sgn;
	logic [XLEN-1:0] a_mag;
	logic [XLEN-1:0] b_mag;

	assign div_sgn = (f3_s1 == F3_DIV) || (f3_s1 == F3_REM);
	assign a_mag   = (div_sgn && a_s1[XLEN-1]) ? (XLEN'(0) - a_s1) : a_s1;
	assign b_mag   = (div_sgn && b_s1[XLEN-1]) ? (XLEN'(0) - b_s1) : b_s1;

	logic               vld_s2;
	logic [XLEN-1:0]    base_s2;
	logic [31:0]        pp_ll_s2;
	logic signed [34:0] pp_lh_s2;
	logic signed [34:0] pp_hl_s2;
	logic signed [33:0] pp_hh_s2;
	logic [2:0]         f3_s2;
	logic               is_m_s2;
	logic [XLEN-1:0]    dvd_s2;
	logic [XLEN-1:0]    dvs_s2;
	logic               neg_q_s2;
	logic               neg_r_s2;
	logic [4:0]         rd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s2  <= base_res;
			pp_ll_s2 <= ax[15:0] * bx[15:0];
			pp_lh_s2 <= $signed({2'b00, ax[15:0]}) * $signed(bx[32:16]);
			pp_hl_s2 <= $signed(ax[32:16]) * $signed({2'b00, bx[15:0]});
			pp_hh_s2 <= $signed(ax[32:16]) * $signed(bx[32:16]);
			f3_s2    <= f3_s1;
			is_m_s2  <= is_m_s1;
			dvd_s2   <= a_mag;
			dvs_s2   <= b_mag;
			// divide by zero keeps the all-ones quotient unsigned
			neg_q_s2 <= (f3_s1 == F3_DIV) && (a_s1[XLEN-1] ^ b_s1[XLEN-1]) && (b_s1 != '0);
			neg_r_s2 <= (f3_s1 == F3_REM) && a_s1[XLEN-1];
			rd_s2    <= rd_s1;
		end
	end

	// ---------------- product sum, non-divide result (s3) ----------------
	logic [63:0] prod;
	logic [XLEN-1:0] other_res;

	assign prod = {32'd0, pp_ll_s2}
		+ (64'($signed(pp_lh_s2)) << 16)
		+ (64'($signed(pp_hl_s2)) << 16)
		+ (64'($signed(pp_hh_s2)) << 32);

	always_comb begin
		if (!is_m_s2) begin
			other_res = base_s2;
		end else if (f3_s2 == F3_MUL) begin
			other_res = prod[31:0];
		end else begin
			other_res = prod[63:32];
		end
	end

	logic            vld_s3;
	side_t           side_s3;
	logic [XLEN-1:0] dvd_s3;
	logic [XLEN-1:0] dvs_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.other  <= other_res;
			side_s3.is_div <= is_m_s2 && f3_s2[2];
			side_s3.is_rem <= f3_s2[1];
			side_s3.neg_q  <= neg_q_s2;
			side_s3.neg_r  <= neg_r_s2;
			side_s3.rd     <= rd_s2;
			dvd_s3         <= dvd_s2;
			dvs_s3         <= dvs_s2;
		end
	end

	// ---------------- divider spine ----------------
	logic            div_vld;
	logic [XLEN-1:0] div_q;
	logic [XLEN-1:0] div_r;
	side_t           div_side;

	rvalu_divpipe u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (vld_s3),
		.in_dividend (dvd_s3),
		.in_divisor  (dvs_s3),
		.in_side     (side_s3),
		.out_valid   (div_vld),
		.out_quot    (div_q),
		.out_rem     (div_r),
		.out_side    (div_side)
	);

	// ---------------- output register ----------------
	logic [XLEN-1:0] final_res;

	always_comb begin
		if (!div_side.is_div) begin
			final_res = div_side.other;
		end else if (div_side.is_rem) begin
			final_res = div_side.neg_r ? (XLEN'(0) - div_r) : div_r;
		end else begin
			final_res = div_side.neg_q ? (XLEN'(0) - div_q) : div_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_value <= final_res;
			dest_index   <= div_side.rd;
			write_enable <= (div_side.rd != 5'd0);
		end
	end

endmodule

>>> design/rvalu_checker.sv
`include "assert_macros.svh"

module rvalu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        instr_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [31:0] result_value,
	input logic [4:0]  dest_index,
	input logic        write_enable
);

	// a stalled result stays put
	`ASSERT_IMPL(a_hold, clk, arst_n, result_valid && result_stall, ##1 (result_valid && $stable(result_value) && $stable(dest_index)), "stalled result changed")

	// the pipe backs up onto the request side exactly when the output is stuck
	`ASSERT_CLK(a_backpressure, clk, arst_n, instr_stall == (result_valid && result_stall), "request stall does not match output stall")

	// x0 never gets written
	`ASSERT_IMPL(a_x0, clk, arst_n, result_valid, write_enable == (dest_index != 5'd0), "write enable does not match destination")

endmodule

bind rv32im_integer_alu rvalu_checker u_rvalu_checker (.*);

>>> tb/alu_checker.sv
module alu_checker
	import rvalu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instr_valid,
	input  logic        instr_stall,
	input  logic [31:0] instruction,
	input  logic [31:0] first_operand,
	input  logic [31:0] second_operand,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [31:0] result_value,
	input  logic [4:0]  dest_index,
	input  logic        write_enable,
	output int          fail_count,
	output int          pending_count,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] value;
		logic [4:0]  rd;
		logic        we;
	} writeback_t;

	writeback_t writeback_q[$];

	function automatic logic [31:0] muldiv_result(logic [2:0] f3, logic [31:0] a,
		logic [31:0] b);
		logic [63:0] prod;
		logic [31:0] ma, mb, q, r;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		case (f3)
			F3_MUL: return a * b;
			F3_MULH: begin
				prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
				return prod[63:32];
			end
			F3_MULHSU: begin
				prod = {{32{a[31]}}, a} * {32'b0, b};
				return prod[63:32];
			end
			F3_MULHU: begin
				prod = {32'b0, a} * {32'b0, b};
				return prod[63:32];
			end
			F3_DIV: begin
				if (b == 0) return 32'hFFFFFFFF;
				q = ma / mb;
				return (a[31] ^ b[31]) ? -q : q;
			end
			F3_DIVU: return (b == 0) ? 32'hFFFFFFFF : a / b;
			F3_REM: begin
				if (b == 0) return a;
				r = ma % mb;
				return a[31] ? -r : r;
			end
			default: return (b == 0) ? a : a % b;
		endcase
	endfunction

	function automatic logic [31:0] base_result(logic [2:0] f3, logic [31:0] a,
		logic [31:0] b, logic alt);
		logic [4:0] sh;
		sh = b[4:0];
		case (f3)
			F3_ADD:  return alt ? a - b : a + b;
			F3_SLL:  return a << sh;
			F3_SLT:  return {31'b0, $signed(a) < $signed(b)};
			F3_SLTU: return {31'b0, a < b};
			F3_XOR:  return a ^ b;
			F3_SR:   return alt ? $unsigned($signed(a) >>> sh) : a >> sh;
			F3_OR:   return a | b;
			default: return a & b;
		endcase
	endfunction

	function automatic writeback_t predict_writeback(logic [31:0] ins, logic [31:0] a,
		logic [31:0] b);
		writeback_t w;
		logic [31:0] imm;
		imm = {{20{ins[31]}}, ins[31:20]};
		if (ins[5]) begin
			if (ins[31:25] == F7_MULDIV)
				w.value = muldiv_result(ins[14:12], a, b);
			else
				w.value = base_result(ins[14:12], a, b, ins[31:25] == F7_ALT);
		end else begin
			w.value = base_result(ins[14:12], a, imm, ins[14:12] == F3_SR && ins[30]);
		end
		w.rd = ins[11:7];
		w.we = ins[11:7] != 0;
		return w;
	endfunction

	assign pending_count = writeback_q.size();

	always @(posedge clk or negedge arst_n) begin
		writeback_t exp_w;
		if (!arst_n) begin
			fail_count   <= 0;
			results_seen <= 0;
			writeback_q.delete();
		end else begin
			if (instr_valid && !instr_stall)
				writeback_q.push_back(predict_writeback(instruction, first_operand,
					second_operand));
			if (result_valid && !result_stall) begin
				results_seen <= results_seen + 1;
				if (writeback_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %h rd %0d", result_value, dest_index);
					fail_count <= fail_count + 1;
				end else begin
					exp_w = writeback_q.pop_front();
					if (exp_w.value !== result_value || exp_w.rd !== dest_index ||
						exp_w.we !== write_enable) begin
						if (fail_count < 10)
							$display("mismatch: exp %h/%0d/%b got %h/%0d/%b", exp_w.value,
								exp_w.rd, exp_w.we, result_value, dest_index, write_enable);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

>>> tb/testbench.sv
module testbench;
	import rvalu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 36;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        instr_valid = 0;
	logic        instr_stall;
	logic [31:0] instruction = 0;
	logic [31:0] first_operand = 0;
	logic [31:0] second_operand = 0;
	logic        result_valid;
	logic        result_stall = 0;
	logic [31:0] result_value;
	logic [4:0]  dest_index;
	logic        write_enable;
	int          fail_count, pending_count, results_seen;
	int          sent_count = 0;
	bit          long_hold = 0;  // receiver holds off while high

	// opcode values for the two instruction forms
	localparam logic [6:0] OPC_OP     = 7'b0110011;
	localparam logic [6:0] OPC_OP_IMM = 7'b0010011;

	always #4 clk = ~clk;

	rv32im_integer_alu u_top (.*);

	alu_checker u_checker (.*);

	// one request: drive at falling edge, hold until accepted at a rising edge
	task automatic send_request(logic [31:0] ins, logic [31:0] a, logic [31:0] b);
		instr_valid    <= 1;
		instruction    <= ins;
		first_operand  <= a;
		second_operand <= b;
		@(posedge clk);
		while (instr_stall) @(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic idle_cycles(int n);
		instr_valid <= 0;
		repeat (n) @(negedge clk);
	endtask

	// operand values that hit sign and overflow corners
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h80000000;
			1: return 32'hFFFFFFFF;
			2: return 32'h0;
			3: return 32'h1;
			4: return $urandom_range(0, 40);
			default: return $urandom;
		endcase
	endfunction

	// mostly well-formed op / op-imm words, some raw noise
	function automatic logic [31:0] pick_instruction();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2: w[31:25] = F7_MULDIV;
			3, 4: w[31:25] = F7_ALT;
			5: w[31:25] = 7'h0;
			default: ;
		endcase
		if ($urandom_range(0, 9) != 0)
			w[6:0] = $urandom_range(0, 1) ? OPC_OP : OPC_OP_IMM;
		return w;
	endfunction

	// receiver stall pattern, plus one long hold-off while long_hold is high
	always @(negedge clk) begin
		if (long_hold)
			result_stall <= 1;
		else if ($urandom_range(0, 3) == 0)
			result_stall <= ($urandom_range(0, 2) != 0);
		else if ($urandom_range(0, 1) == 0)
			result_stall <= 0;
	end

	initial begin
		#2_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		int burst;
		logic [2:0] f3;
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: every m-extension op and every base funct3 (sub, sra) with corner operands
		for (int i = 0; i < 8; i++) begin
			f3 = 3'(i);
			send_request({F7_MULDIV, 5'd2, 5'd1, f3, 5'd3, OPC_OP}, 32'h80000000,
				32'hFFFFFFFF);
			send_request({F7_MULDIV, 5'd2, 5'd1, f3, 5'd0, OPC_OP}, 32'h7FFFFFFF, 32'h0);
			send_request({(f3 == F3_ADD || f3 == F3_SR) ? F7_ALT : 7'h0, 5'd2, 5'd1, f3,
				5'd31, OPC_OP}, 32'h80000000, 32'hFFFFFFFF);
		end
		// srai and immediate extremes
		send_request({F7_ALT, 5'd31, 5'd1, F3_SR, 5'd4, OPC_OP_IMM}, 32'h80000000, 0);
		send_request({12'h800, 5'd1, F3_ADD, 5'd4, OPC_OP_IMM}, 32'hFFFFFFFF, 0);
		send_request({12'h7FF, 5'd1, F3_SLTU, 5'd4, OPC_OP_IMM}, 32'h0, 0);

		// sender pauses until all results are back
		instr_valid <= 0;
		while (pending_count != 0) @(negedge clk);

		// long receiver hold-off while requests keep coming
		long_hold = 1;
		fork
			begin
				repeat (120) @(negedge clk);
				long_hold = 0;
			end
			repeat (60) send_request(pick_instruction(), pick_operand(), pick_operand());
		join

		while (sent_count < 950) begin
			burst = $urandom_range(1, 40);
			repeat (burst) send_request(pick_instruction(), pick_operand(), pick_operand());
			if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
		end
		instr_valid <= 0;

		while (pending_count != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);

		$display("sent %0d requests (all op/op-imm forms, corners, long back-pressure)",
			sent_count);
		$display("checked %0d results", results_seen);
		if (fail_count == 0 && pending_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
